// File: sv/assert_macros.svh
// Assertion macros used by the handle list top level.
// Depends on nothing; included by files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define CHL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define CHL_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
    `CHL_ASSERT(label, clk, rst_n, (cond) |=> (conseq), msg)

`endif

// File: sv/chl_pkg.sv
// Types, codes and sizes shared by the handle list cells and top level.
// Depends on nothing.
package chl_pkg;

    localparam int CAPACITY = 16;
    localparam int HANDLE_W = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        CMD_APPEND       = 3'd0,
        CMD_REMOVE_VALUE = 3'd1,
        CMD_REMOVE_INDEX = 3'd2,
        CMD_GET          = 3'd3,
        CMD_FIND         = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ERR_OK     = 2'd0,
        ERR_FULL   = 2'd1,
        ERR_UNUSED = 2'd2,
        ERR_ABSENT = 2'd3
    } t_err;

    // Command broadcast to every cell in the row.
    typedef struct packed {
        logic                append;
        logic                rm_value;
        logic                rm_index;
        logic [HANDLE_W-1:0] handle;
        logic [IDX_W-1:0]    pos;
        logic [CNT_W-1:0]    count;
    } t_cell_cmd;

    // Search and read results handed from cell to cell.
    typedef struct packed {
        logic                seen;
        logic [IDX_W-1:0]    idx;
        logic [HANDLE_W-1:0] data;
    } t_chain;

endpackage

// File: sv/chl_cell.sv
// One list cell: holds one handle, compares it, shifts down from its neighbor.
// Depends on chl_pkg.
module chl_cell (
    input  logic                         i_clk,
    input  chl_pkg::t_cell_cmd           i_cmd,
    input  logic [chl_pkg::IDX_W-1:0]    i_index,
    input  logic [chl_pkg::HANDLE_W-1:0] i_next_entry,
    input  chl_pkg::t_chain              i_chain,
    output chl_pkg::t_chain              o_chain,
    output logic [chl_pkg::HANDLE_W-1:0] o_entry
);

    logic [chl_pkg::HANDLE_W-1:0] r_entry;
    logic [chl_pkg::HANDLE_W-1:0] n_entry;
    logic [chl_pkg::CNT_W-1:0]    idx_c;
    logic [chl_pkg::CNT_W-1:0]    idx_up;
    logic                         used;
    logic                         hit;
    logic                         above_gap;
    logic                         shift;
    logic                         write;

    assign idx_c     = chl_pkg::CNT_W'(i_index);
    assign idx_up    = idx_c + chl_pkg::CNT_W'(1);
    assign used      = idx_c < i_cmd.count;
    assign hit       = used && (r_entry == i_cmd.handle);
    assign above_gap = idx_up < i_cmd.count;
    assign shift     = above_gap && ((i_cmd.rm_value && (i_chain.seen || hit))
                                  || (i_cmd.rm_index && (i_index >= i_cmd.pos)));
    assign write     = i_cmd.append && (idx_c == i_cmd.count);

    always_comb begin
        priority if (shift) begin
            n_entry = i_next_entry;
        end else if (write) begin
            n_entry = i_cmd.handle;
        end else begin
            n_entry = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    always_comb begin
        o_chain.seen = i_chain.seen || hit;
        if (i_chain.seen) begin
            o_chain.idx = i_chain.idx;
        end else if (hit) begin
            o_chain.idx = i_index;
        end else begin
            o_chain.idx = '0;
        end
        o_chain.data = (i_index == i_cmd.pos) ? r_entry : i_chain.data;
    end

    assign o_entry = r_entry;

endmodule

// File: sv/compacting_handle_list.sv
// Top level of the compacting handle list: a row of cells plus count and result register.
// Depends on chl_pkg, chl_cell and assert_macros.svh.
//
//  channel | valid       | stall        | fields
//  --------+-------------+--------------+-----------------------------------------------
//  command | i_in_valid  | o_in_stall   | i_command, i_handle_in, i_position
//  result  | o_out_valid | i_out_stall  | o_handle_out, o_found_index, o_count_now,
//          |             |              | o_error_code
//
// All cells compare and shift at once, and the result shows in the output register on the
// next cycle; one item per cycle sustained while the result side is not stalled.
// A held result (i_out_stall high with o_out_valid) stalls the command side.
// Reset clears the count and the result valid; cell contents are left as they are.
`include "assert_macros.svh"

module compacting_handle_list (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [2:0]                   i_command,
    input  logic [chl_pkg::HANDLE_W-1:0] i_handle_in,
    input  logic [chl_pkg::IDX_W-1:0]    i_position,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [chl_pkg::HANDLE_W-1:0] o_handle_out,
    output logic [chl_pkg::IDX_W-1:0]    o_found_index,
    output logic [chl_pkg::CNT_W-1:0]    o_count_now,
    output logic [1:0]                   o_error_code
);

    logic                         r_out_valid;
    logic [chl_pkg::CNT_W-1:0]    r_count;
    logic [chl_pkg::CNT_W-1:0]    n_count;
    logic [chl_pkg::HANDLE_W-1:0] r_handle_out;
    logic [chl_pkg::HANDLE_W-1:0] n_handle_out;
    logic [chl_pkg::IDX_W-1:0]    r_found_index;
    logic [chl_pkg::IDX_W-1:0]    n_found_index;
    chl_pkg::t_err                r_error_code;
    chl_pkg::t_err                n_error_code;

    logic                         in_acc;
    logic                         out_acc;
    chl_pkg::t_cmd                cmd;
    logic                         full;
    logic                         pos_ok;
    logic                         found;
    chl_pkg::t_cell_cmd           cell_cmd;
    chl_pkg::t_chain              chain [chl_pkg::CAPACITY+1];
    logic [chl_pkg::HANDLE_W-1:0] entry [chl_pkg::CAPACITY];

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_acc    = r_out_valid && !i_out_stall;

    assign cmd    = chl_pkg::t_cmd'(i_command);
    assign full   = r_count == chl_pkg::CNT_W'(chl_pkg::CAPACITY);
    assign pos_ok = chl_pkg::CNT_W'(i_position) < r_count;
    assign found  = chain[chl_pkg::CAPACITY].seen;

    always_comb begin
        cell_cmd.append   = in_acc && (cmd == chl_pkg::CMD_APPEND);
        cell_cmd.rm_value = in_acc && (cmd == chl_pkg::CMD_REMOVE_VALUE);
        cell_cmd.rm_index = in_acc && (cmd == chl_pkg::CMD_REMOVE_INDEX);
        cell_cmd.handle   = i_handle_in;
        cell_cmd.pos      = i_position;
        cell_cmd.count    = r_count;
    end

    assign chain[0] = '{seen: 1'b0, idx: '0, data: '0};

    for (genvar g = 0; g < chl_pkg::CAPACITY; g++) begin : g_cell
        logic [chl_pkg::HANDLE_W-1:0] next_entry;
        if (g == chl_pkg::CAPACITY - 1) begin : g_last
            assign next_entry = '0;
        end else begin : g_mid
            assign next_entry = entry[g+1];
        end
        chl_cell u_cell (
            .i_clk        (i_clk),
            .i_cmd        (cell_cmd),
            .i_index      (chl_pkg::IDX_W'(g)),
            .i_next_entry (next_entry),
            .i_chain      (chain[g]),
            .o_chain      (chain[g+1]),
            .o_entry      (entry[g])
        );
    end

    always_comb begin
        n_count       = r_count;
        n_handle_out  = '0;
        n_found_index = '0;
        n_error_code  = chl_pkg::ERR_OK;
        unique case (cmd)
            chl_pkg::CMD_APPEND: begin
                if (full) begin
                    n_error_code = chl_pkg::ERR_FULL;
                end else begin
                    n_count = r_count + chl_pkg::CNT_W'(1);
                end
            end
            chl_pkg::CMD_REMOVE_VALUE: begin
                if (found) begin
                    n_found_index = chain[chl_pkg::CAPACITY].idx;
                    n_count       = r_count - chl_pkg::CNT_W'(1);
                end else begin
                    n_error_code = chl_pkg::ERR_ABSENT;
                end
            end
            chl_pkg::CMD_REMOVE_INDEX: begin
                if (pos_ok) begin
                    n_count = r_count - chl_pkg::CNT_W'(1);
                end else begin
                    n_error_code = chl_pkg::ERR_UNUSED;
                end
            end
            chl_pkg::CMD_GET: begin
                if (pos_ok) begin
                    n_handle_out = chain[chl_pkg::CAPACITY].data;
                end else begin
                    n_error_code = chl_pkg::ERR_UNUSED;
                end
            end
            chl_pkg::CMD_FIND: begin
                if (found) begin
                    n_found_index = chain[chl_pkg::CAPACITY].idx;
                end else begin
                    n_error_code = chl_pkg::ERR_ABSENT;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            if (in_acc) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_handle_out  <= n_handle_out;
            r_found_index <= n_found_index;
            r_error_code  <= n_error_code;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_handle_out  = r_handle_out;
    assign o_found_index = r_found_index;
    assign o_count_now   = r_count;
    assign o_error_code  = r_error_code;

    `CHL_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= chl_pkg::CNT_W'(chl_pkg::CAPACITY), "count beyond capacity")
    `CHL_ASSERT_NEXT(a_count_hold, i_clk, i_rst_n, !in_acc, $stable(r_count), "count moved without an item")
    `CHL_ASSERT_NEXT(a_full_err, i_clk, i_rst_n, in_acc && cmd == chl_pkg::CMD_APPEND && full, o_error_code == chl_pkg::ERR_FULL && full, "append to full list not flagged")
    `CHL_ASSERT_NEXT(a_result_up, i_clk, i_rst_n, in_acc, o_out_valid, "accepted item gave no result")

endmodule

// File: tb/chl_checker.sv
// Scoreboard for the compacting handle list: watches both channels, models the list
// and compares each result item with the oldest prediction.
// Depends on chl_pkg.
module chl_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic [2:0]                   i_command,
    input  logic [chl_pkg::HANDLE_W-1:0] i_handle_in,
    input  logic [chl_pkg::IDX_W-1:0]    i_position,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic [chl_pkg::HANDLE_W-1:0] i_handle_out,
    input  logic [chl_pkg::IDX_W-1:0]    i_found_index,
    input  logic [chl_pkg::CNT_W-1:0]    i_count_now,
    input  logic [1:0]                   i_error_code,
    output int                           o_pending,
    output int                           o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [chl_pkg::HANDLE_W-1:0] handle;
        logic [chl_pkg::IDX_W-1:0]    index;
        logic [chl_pkg::CNT_W-1:0]    count;
        chl_pkg::t_err                err;
    } t_list_reply;

    logic [chl_pkg::HANDLE_W-1:0] slots [chl_pkg::CAPACITY];
    int                           fill;
    t_list_reply                  replies_due [$];
    t_list_reply                  oldest;
    int                           fails = 0;

    assign o_fail_count = fails;

    function automatic t_list_reply apply_command(logic [2:0] cmd,
                                                  logic [chl_pkg::HANDLE_W-1:0] h,
                                                  logic [chl_pkg::IDX_W-1:0] pos);
        t_list_reply r;
        int          hit;
        int          drop;
        r    = '0;
        hit  = -1;
        drop = -1;
        for (int i = 0; i < fill; i++)
            if (hit < 0 && slots[i] == h)
                hit = i;
        case (cmd)
            chl_pkg::CMD_APPEND: begin
                if (fill >= chl_pkg::CAPACITY)
                    r.err = chl_pkg::ERR_FULL;
                else begin
                    slots[fill] = h;
                    fill++;
                end
            end
            chl_pkg::CMD_REMOVE_VALUE, chl_pkg::CMD_FIND: begin
                if (hit < 0)
                    r.err = chl_pkg::ERR_ABSENT;
                else begin
                    r.index = hit[chl_pkg::IDX_W-1:0];
                    if (cmd == chl_pkg::CMD_REMOVE_VALUE)
                        drop = hit;
                end
            end
            chl_pkg::CMD_REMOVE_INDEX, chl_pkg::CMD_GET: begin
                if (int'(pos) >= fill)
                    r.err = chl_pkg::ERR_UNUSED;
                else if (cmd == chl_pkg::CMD_GET)
                    r.handle = slots[pos];
                else
                    drop = int'(pos);
            end
            default: ;
        endcase
        // close the gap: move later entries down one place
        if (drop >= 0) begin
            for (int i = drop; i + 1 < fill; i++)
                slots[i] = slots[i + 1];
            fill--;
        end
        r.count = fill[chl_pkg::CNT_W-1:0];
        return r;
    endfunction

    task automatic report(string field, logic [chl_pkg::HANDLE_W-1:0] got,
                          logic [chl_pkg::HANDLE_W-1:0] want);
        $display("%0t chl_checker: %s got %0h, want %0h", $realtime, field, got, want);
        fails++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fill = 0;
            replies_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (replies_due.size() == 0)
                    report("unpredicted result item, handle_out", i_handle_out, '0);
                else begin
                    oldest = replies_due.pop_front();
                    if (i_handle_out !== oldest.handle)
                        report("handle_out", i_handle_out, oldest.handle);
                    if (i_found_index !== oldest.index)
                        report("found_index", chl_pkg::HANDLE_W'(i_found_index),
                               chl_pkg::HANDLE_W'(oldest.index));
                    if (i_count_now !== oldest.count)
                        report("count_now", chl_pkg::HANDLE_W'(i_count_now),
                               chl_pkg::HANDLE_W'(oldest.count));
                    if (i_error_code !== oldest.err)
                        report("error_code", chl_pkg::HANDLE_W'(i_error_code),
                               chl_pkg::HANDLE_W'(oldest.err));
                end
            end
            if (i_in_valid && !i_in_stall)
                replies_due.push_back(apply_command(i_command, i_handle_in, i_position));
        end
        o_pending <= replies_due.size();
    end

endmodule

// File: tb/tb_compacting_handle_list.sv
// Testbench top for the compacting handle list: clock, reset, command stimulus with
// random gaps and result stalls, watchdog and verdict.
// Depends on chl_pkg, compacting_handle_list and chl_checker.
module tb_compacting_handle_list;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CMD_RESERVED = 3'd5;
    localparam int         IDLE_LIMIT   = 3000;
    localparam int         PHASE_ITEMS  = 240;

    typedef enum {MIX_GROW, MIX_SHRINK, MIX_EVEN} t_mix;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic [2:0]                   command = '0;
    logic [chl_pkg::HANDLE_W-1:0] handle_in = '0;
    logic [chl_pkg::IDX_W-1:0]    position = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [chl_pkg::HANDLE_W-1:0] handle_out;
    logic [chl_pkg::IDX_W-1:0]    found_index;
    logic [chl_pkg::CNT_W-1:0]    count_now;
    logic [1:0]                   error_code;
    logic                         calm = 1'b1;
    int                           stall_left = 0;
    int                           idle_cycles = 0;
    int                           pending;
    int                           fail_count;
    logic [chl_pkg::HANDLE_W-1:0] recent [8];

    always #5 i_clk = ~i_clk;

    compacting_handle_list uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_command     (command),
        .i_handle_in   (handle_in),
        .i_position    (position),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_handle_out  (handle_out),
        .o_found_index (found_index),
        .o_count_now   (count_now),
        .o_error_code  (error_code)
    );

    chl_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_command     (command),
        .i_handle_in   (handle_in),
        .i_position    (position),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_handle_out  (handle_out),
        .i_found_index (found_index),
        .i_count_now   (count_now),
        .i_error_code  (error_code),
        .o_pending     (pending),
        .o_fail_count  (fail_count)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [2:0] pick_cmd(t_mix mix);
        int r;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_GROW:   r = (r < 55) ? 0 : (r < 62) ? 1 : (r < 69) ? 2 : (r < 82) ? 3 :
                            (r < 96) ? 4 : 5;
            MIX_SHRINK: r = (r < 15) ? 0 : (r < 45) ? 1 : (r < 70) ? 2 : (r < 82) ? 3 :
                            (r < 96) ? 4 : 5;
            default:    r = (r < 30) ? 0 : (r < 45) ? 1 : (r < 60) ? 2 : (r < 78) ? 3 :
                            (r < 96) ? 4 : 5;
        endcase
        case (r)
            0:       return chl_pkg::CMD_APPEND;
            1:       return chl_pkg::CMD_REMOVE_VALUE;
            2:       return chl_pkg::CMD_REMOVE_INDEX;
            3:       return chl_pkg::CMD_GET;
            4:       return chl_pkg::CMD_FIND;
            default: return CMD_RESERVED + 3'($urandom_range(0, 2));
        endcase
    endfunction

    function automatic logic [chl_pkg::HANDLE_W-1:0] pick_handle();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return recent[$urandom_range(0, 7)];
        else if (r == 6)
            return '0;
        else if (r == 7)
            return '1;
        return $urandom;
    endfunction

    task automatic send_cmd(logic [2:0] cmd, logic [chl_pkg::HANDLE_W-1:0] h,
                            logic [chl_pkg::IDX_W-1:0] pos);
        int gap;
        in_valid  <= 1'b1;
        command   <= cmd;
        handle_in <= h;
        position  <= pos;
        do @(posedge i_clk); while (in_stall);
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // result side back-pressure
    always @(posedge i_clk) begin
        if (calm || stall_left == 0) begin
            out_stall  <= 1'b0;
            stall_left <= calm ? 0 : pick_gap();
        end else begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_compacting_handle_list: done, errors");
            $finish;
        end
    end

    initial begin
        logic [2:0]                   cmd;
        logic [chl_pkg::HANDLE_W-1:0] h;
        logic [chl_pkg::IDX_W-1:0]    pos;
        t_mix                         mix;
        foreach (recent[i])
            recent[i] = $urandom;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list, extremes, duplicates, first and last removal
        send_cmd(chl_pkg::CMD_GET, '0, 4'd0);
        send_cmd(chl_pkg::CMD_REMOVE_INDEX, '0, 4'd15);
        send_cmd(chl_pkg::CMD_REMOVE_VALUE, '0, '0);
        send_cmd(chl_pkg::CMD_FIND, '1, '0);
        send_cmd(CMD_RESERVED, '1, '1);
        send_cmd(chl_pkg::CMD_APPEND, '0, '0);
        send_cmd(chl_pkg::CMD_APPEND, '1, '1);
        send_cmd(chl_pkg::CMD_APPEND, '0, '0);
        send_cmd(chl_pkg::CMD_APPEND, 32'h5a5a_a5a5, '0);
        send_cmd(chl_pkg::CMD_FIND, '0, '0);
        send_cmd(chl_pkg::CMD_FIND, '1, '0);
        send_cmd(chl_pkg::CMD_GET, '0, 4'd1);
        send_cmd(chl_pkg::CMD_REMOVE_VALUE, '0, '0);
        send_cmd(chl_pkg::CMD_GET, '0, 4'd0);
        send_cmd(chl_pkg::CMD_FIND, '0, '0);
        send_cmd(chl_pkg::CMD_GET, '0, 4'd3);
        send_cmd(chl_pkg::CMD_REMOVE_INDEX, '0, 4'd2);
        send_cmd(chl_pkg::CMD_REMOVE_INDEX, '0, 4'd0);
        send_cmd(chl_pkg::CMD_FIND, 32'h5a5a_a5a5, '0);
        send_cmd(CMD_RESERVED + 3'd2, 32'h1234_5678, 4'd9);

        for (int phase = 0; phase < 6; phase++) begin
            case (phase % 3)
                0:       mix = MIX_GROW;
                1:       mix = MIX_SHRINK;
                default: mix = MIX_EVEN;
            endcase
            calm <= (phase == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                cmd = pick_cmd(mix);
                h   = pick_handle();
                pos = $urandom_range(0, 1) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
                if (cmd == chl_pkg::CMD_APPEND && $urandom_range(0, 2) == 0) begin
                    h = $urandom;
                    recent[$urandom_range(0, 7)] = h;
                end
                send_cmd(cmd, h, pos);
            end
        end

        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb_compacting_handle_list: done, clean");
        else
            $display("tb_compacting_handle_list: done, errors");
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/chl_pkg.sv
sv/chl_cell.sv
sv/compacting_handle_list.sv
tb/chl_checker.sv
tb/tb_compacting_handle_list.sv
